// ----- sv/lclf_pkg.sv -----
// ----------------------------------------------------------------------------
// lclf_pkg
// Shared types and codes for the link channel lifecycle controller: event,
// command and notice codes, the channel flag set, and the beat structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lclf_pkg;

  localparam int unsigned LenW = 16;

  typedef enum logic [2:0] {
    EV_OPEN       = 3'd0,
    EV_CLOSE      = 3'd1,
    EV_WRITE_REQ  = 3'd2,
    EV_READ_REQ   = 3'd3,
    EV_OPEN_DONE  = 3'd4,
    EV_READ_DONE  = 3'd5,
    EV_WRITE_DONE = 3'd6
  } event_e;

  typedef enum logic [2:0] {
    CMD_NONE        = 3'd0,
    CMD_OPEN        = 3'd1,
    CMD_CLOSE       = 3'd2,
    CMD_ABORT_OPEN  = 3'd3,
    CMD_START_WRITE = 3'd4,
    CMD_START_READ  = 3'd5
  } lower_cmd_e;

  typedef enum logic [2:0] {
    NOTE_NONE      = 3'd0,
    NOTE_LAYER_UP  = 3'd1,
    NOTE_OPEN_FAIL = 3'd2,
    NOTE_SEND_DONE = 3'd3,
    NOTE_DATA_RECV = 3'd4
  } notice_e;

  typedef struct packed {
    logic open_flag;
    logic opening_flag;
    logic reading_flag;
    logic writing_flag;
    logic closing_flag;
  } flags_t;

  typedef struct packed {
    logic [2:0]      req_type;
    logic [LenW-1:0] length;
    logic            failed;
  } evt_t;

  typedef struct packed {
    logic            rejected;
    logic [2:0]      lower_cmd;
    logic [LenW-1:0] xfer_len;
    logic [2:0]      notice;
    logic            layer_down;
    logic            is_open;
    logic            is_opening;
    logic            is_reading;
    logic            is_writing;
    logic            is_closing;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/lclf_event_logic.sv -----
// ----------------------------------------------------------------------------
// lclf_event_logic
// Guard decode and flag update for one event: gives the next flag set and
// the result beat for the event held in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module lclf_event_logic (
  input  wire lclf_pkg::evt_t   evt,
  input  wire lclf_pkg::flags_t flags,
  output lclf_pkg::flags_t      flags_next,
  output lclf_pkg::res_t        res
);
  import lclf_pkg::*;

  always_comb begin
    flags_t          n;
    logic            rej;
    logic [2:0]      cmd;
    logic [LenW-1:0] xlen;
    logic [2:0]      note;
    logic            down;
    logic            len_zero;

    n        = flags;
    rej      = 1'b0;
    cmd      = CMD_NONE;
    xlen     = '0;
    note     = NOTE_NONE;
    down     = 1'b0;
    len_zero = (evt.length == '0);

    case (evt.req_type)
      EV_OPEN: begin
        if (!(flags.opening_flag || flags.reading_flag || flags.writing_flag ||
              flags.open_flag || flags.closing_flag)) begin
          n.opening_flag = 1'b1;
          cmd            = CMD_OPEN;
        end else begin
          rej = 1'b1;
        end
      end
      EV_CLOSE: begin
        // close while closing is dropped silently
        if (!flags.closing_flag) begin
          if (flags.open_flag || flags.opening_flag) begin
            n.closing_flag = 1'b1;
            cmd = flags.opening_flag ? CMD_ABORT_OPEN : CMD_CLOSE;
            if (!(flags.opening_flag || flags.reading_flag || flags.writing_flag)) begin
              n.closing_flag = 1'b0;
              n.open_flag    = 1'b0;
              down           = 1'b1;
            end
          end else begin
            rej = 1'b1;
          end
        end
      end
      EV_WRITE_REQ: begin
        if (flags.open_flag && !flags.closing_flag && !flags.writing_flag) begin
          if (!len_zero) begin
            n.writing_flag = 1'b1;
            cmd            = CMD_START_WRITE;
            xlen           = evt.length;
          end else begin
            note = NOTE_SEND_DONE;
          end
        end else begin
          rej = 1'b1;
        end
      end
      EV_READ_REQ: begin
        if (flags.open_flag && !flags.closing_flag && !flags.reading_flag) begin
          if (!len_zero) begin
            n.reading_flag = 1'b1;
            cmd            = CMD_START_READ;
            xlen           = evt.length;
          end else begin
            note = NOTE_DATA_RECV;
          end
        end else begin
          rej = 1'b1;
        end
      end
      EV_OPEN_DONE: begin
        if (flags.opening_flag) begin
          n.opening_flag = 1'b0;
          if (evt.failed || flags.closing_flag) begin
            if (!evt.failed) cmd = CMD_CLOSE;
            note = NOTE_OPEN_FAIL;
            // finish the close if nothing else is pending, no layer-down here
            if (n.closing_flag && !(n.reading_flag || n.writing_flag)) begin
              n.closing_flag = 1'b0;
              n.open_flag    = 1'b0;
            end
          end else begin
            n.open_flag = 1'b1;
            note        = NOTE_LAYER_UP;
          end
        end else begin
          rej = 1'b1;
        end
      end
      EV_READ_DONE, EV_WRITE_DONE: begin
        if ((evt.req_type == EV_READ_DONE) ? flags.reading_flag : flags.writing_flag) begin
          if (evt.req_type == EV_READ_DONE) n.reading_flag = 1'b0;
          else n.writing_flag = 1'b0;
          if (evt.failed) begin
            if ((n.open_flag || n.opening_flag) && !n.closing_flag) begin
              n.closing_flag = 1'b1;
              cmd = n.opening_flag ? CMD_ABORT_OPEN : CMD_CLOSE;
            end
          end else if (!flags.closing_flag) begin
            if (evt.req_type == EV_READ_DONE) begin
              note = NOTE_DATA_RECV;
              xlen = evt.length;
            end else begin
              note = NOTE_SEND_DONE;
            end
          end
          if (n.closing_flag && !(n.opening_flag || n.reading_flag || n.writing_flag)) begin
            n.closing_flag = 1'b0;
            n.open_flag    = 1'b0;
            down           = 1'b1;
          end
        end else begin
          rej = 1'b1;
        end
      end
      default: begin
        rej = 1'b1;
      end
    endcase

    flags_next     = n;
    res.rejected   = rej;
    res.lower_cmd  = cmd;
    res.xfer_len   = xlen;
    res.notice     = note;
    res.layer_down = down;
    res.is_open    = n.open_flag;
    res.is_opening = n.opening_flag;
    res.is_reading = n.reading_flag;
    res.is_writing = n.writing_flag;
    res.is_closing = n.closing_flag;
  end

endmodule

`default_nettype wire

// ----- sv/link_channel_lifecycle_fsm.sv -----
// Path: an accepted event beat is held in the input register, then moves into
//   the result register once that register is empty or being drained.
// Throughput: one event per cycle while the result side does not stall; the
//   flag update sits in one short combinational pass between the two registers.
// Reset: synchronous rst clears all five channel flags and both valid bits.
// ----------------------------------------------------------------------------
// link_channel_lifecycle_fsm
// Link channel lifecycle controller: tracks open, opening, reading, writing
// and closing flags, guards each event against them and issues at most one
// lower command, one upper notice and one layer-down per event.
// ----------------------------------------------------------------------------
`default_nettype none

module link_channel_lifecycle_fsm (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 evt_valid,
  output logic                evt_stall,
  input  wire lclf_pkg::evt_t evt,
  output logic                res_valid,
  input  wire                 res_stall,
  output lclf_pkg::res_t      res
);
  import lclf_pkg::*;

  // input register: one event beat waiting for its flag update
  logic   hold_valid;
  evt_t   hold;

  // channel flags, the only control state besides the valid bits
  flags_t flags;
  flags_t flags_next;
  res_t   res_next;

  // advance: the held beat moves into the result register this cycle,
  // which happens whenever the result register is empty or being drained
  logic advance;
  logic take;

  assign advance = hold_valid && (!res_valid || !res_stall);

  // stall the event side only when the held beat cannot advance; an
  // advancing beat frees the input register in the same edge
  assign evt_stall = hold_valid && !advance;
  assign take      = evt_valid && !evt_stall;

  lclf_event_logic u_logic (
    .evt        (hold),
    .flags      (flags),
    .flags_next (flags_next),
    .res        (res_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold <= evt;
    end
  end

  // flags commit as the beat leaves the input register, so the next beat
  // is always checked against the state its predecessor left behind
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (advance) begin
      flags <= flags_next;
    end
  end

  // result register: hold while stalled, load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/lclf_checker.sv -----
// ----------------------------------------------------------------------------
// lclf_checker
// Port-level checks for the link channel lifecycle controller, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lclf_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 evt_valid,
  input wire                 evt_stall,
  input wire lclf_pkg::evt_t evt,
  input wire                 res_valid,
  input wire                 res_stall,
  input wire lclf_pkg::res_t res
);
  import lclf_pkg::*;

  // a rejected event leaves no command, notice, length or layer-down
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.rejected |->
      res.lower_cmd == CMD_NONE && res.notice == NOTE_NONE &&
      res.xfer_len == '0 && !res.layer_down)
    else $error("rejected beat carries side effects");

  // layer-down means the close finished: channel neither open nor closing
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.layer_down |-> !res.is_open && !res.is_closing)
    else $error("layer_down with channel still open or closing");

  // a channel is never open and opening at once
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.is_open && res.is_opening))
    else $error("open and opening flags both set");

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result beat changed");

  // a stalled event beat holds
  assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_stall |=> evt_valid && $stable(evt))
    else $error("stalled event beat changed");

endmodule

bind link_channel_lifecycle_fsm lclf_checker u_lclf_checker (
  .clk       (clk),
  .rst       (rst),
  .evt_valid (evt_valid),
  .evt_stall (evt_stall),
  .evt       (evt),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the link channel lifecycle controller. A queue of
// event beats feeds a driver with random idle cycles; a monitor with random
// stalls compares every result beat with a flag-state predictor of its own.
// ----------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lclf_pkg::*;

  // Event code that the block does not define; it must be refused.
  localparam logic [2:0] EV_UNUSED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LIVE_TARGET = 700;

  // One predicted step: the result beat and the flags it leaves behind.
  typedef struct packed {
    res_t   r;
    flags_t f;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic evt_valid = 1'b0;
  logic evt_stall;
  evt_t evt = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  evt_t        event_backlog[$];
  res_t        owed_results[$];
  flags_t      chan_flags = '0;   // flags as the block should hold them
  flags_t      plan_flags = '0;   // flags as the generator expects them
  int unsigned live_events = 0;   // generated events that the block acts on
  int unsigned beats_in = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  logic        steady;

  link_channel_lifecycle_fsm dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #10 clk = ~clk;

  // Both sides run without idling over one stretch of the run.
  assign steady = (beats_in >= 300) && (beats_in < 450);

  // A close can finish once nothing is pending any more.
  function automatic logic close_ready(input flags_t f);
    return f.closing_flag && !(f.opening_flag || f.reading_flag || f.writing_flag);
  endfunction

  // Predict the result of one event from the flags before it.
  function automatic step_t advance_channel(input flags_t now, input evt_t e);
    step_t s;
    logic  hit;
    s = '0;
    s.f = now;
    case (e.req_type)
      EV_OPEN: begin
        if (now == '0) begin
          s.f.opening_flag = 1'b1;
          s.r.lower_cmd = CMD_OPEN;
        end else begin
          s.r.rejected = 1'b1;
        end
      end
      EV_CLOSE: begin
        // a second close while closing is dropped without a reject
        if (!now.closing_flag) begin
          if (now.open_flag || now.opening_flag) begin
            s.f.closing_flag = 1'b1;
            s.r.lower_cmd = now.opening_flag ? CMD_ABORT_OPEN : CMD_CLOSE;
            if (close_ready(s.f)) begin
              s.f.closing_flag = 1'b0;
              s.f.open_flag = 1'b0;
              s.r.layer_down = 1'b1;
            end
          end else begin
            s.r.rejected = 1'b1;
          end
        end
      end
      EV_WRITE_REQ: begin
        if (now.open_flag && !now.closing_flag && !now.writing_flag) begin
          if (e.length != '0) begin
            s.f.writing_flag = 1'b1;
            s.r.lower_cmd = CMD_START_WRITE;
            s.r.xfer_len = e.length;
          end else begin
            s.r.notice = NOTE_SEND_DONE;
          end
        end else begin
          s.r.rejected = 1'b1;
        end
      end
      EV_READ_REQ: begin
        if (now.open_flag && !now.closing_flag && !now.reading_flag) begin
          if (e.length != '0) begin
            s.f.reading_flag = 1'b1;
            s.r.lower_cmd = CMD_START_READ;
            s.r.xfer_len = e.length;
          end else begin
            s.r.notice = NOTE_DATA_RECV;
          end
        end else begin
          s.r.rejected = 1'b1;
        end
      end
      EV_OPEN_DONE: begin
        if (now.opening_flag) begin
          s.f.opening_flag = 1'b0;
          if (e.failed || now.closing_flag) begin
            // an open that failed or was aborted never raises layer-down
            if (close_ready(s.f)) begin
              s.f.closing_flag = 1'b0;
              s.f.open_flag = 1'b0;
            end
            if (!e.failed) s.r.lower_cmd = CMD_CLOSE;
            s.r.notice = NOTE_OPEN_FAIL;
          end else begin
            s.f.open_flag = 1'b1;
            s.r.notice = NOTE_LAYER_UP;
          end
        end else begin
          s.r.rejected = 1'b1;
        end
      end
      EV_READ_DONE, EV_WRITE_DONE: begin
        hit = (e.req_type == EV_READ_DONE) ? now.reading_flag : now.writing_flag;
        if (hit) begin
          if (e.req_type == EV_READ_DONE) s.f.reading_flag = 1'b0;
          else s.f.writing_flag = 1'b0;
          if (e.failed) begin
            if ((s.f.open_flag || s.f.opening_flag) && !s.f.closing_flag) begin
              s.f.closing_flag = 1'b1;
              s.r.lower_cmd = s.f.opening_flag ? CMD_ABORT_OPEN : CMD_CLOSE;
            end
          end else if (!s.f.closing_flag) begin
            // data that arrives while closing is dropped without a notice
            if (e.req_type == EV_READ_DONE) begin
              s.r.notice = NOTE_DATA_RECV;
              s.r.xfer_len = e.length;
            end else begin
              s.r.notice = NOTE_SEND_DONE;
            end
          end
          if (close_ready(s.f)) begin
            s.f.closing_flag = 1'b0;
            s.f.open_flag = 1'b0;
            s.r.layer_down = 1'b1;
          end
        end else begin
          s.r.rejected = 1'b1;
        end
      end
      default: s.r.rejected = 1'b1;
    endcase
    s.r.is_open = s.f.open_flag;
    s.r.is_opening = s.f.opening_flag;
    s.r.is_reading = s.f.reading_flag;
    s.r.is_writing = s.f.writing_flag;
    s.r.is_closing = s.f.closing_flag;
    return s;
  endfunction

  function automatic logic [15:0] pick_len();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(15, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  // Queue one event and track the flags it should leave.
  task automatic add_event(input logic [2:0] kind, input logic [15:0] len,
                           input logic fail);
    evt_t  e;
    step_t s;
    e.req_type = kind;
    e.length = len;
    e.failed = fail;
    s = advance_channel(plan_flags, e);
    plan_flags = s.f;
    event_backlog.push_back(e);
    if (!s.r.rejected) live_events++;
  endtask

  // Pick the next event from the planned flags: mostly a plausible session,
  // now and then pure noise.
  task automatic add_session_step();
    int unsigned roll;
    int unsigned pick;
    logic        fail;
    roll = $urandom_range(99);
    pick = $urandom_range(9);
    fail = ($urandom_range(99) < 15);
    if (roll < 10) begin
      add_event(3'($urandom_range(7)), 16'($urandom), 1'($urandom_range(1)));
    end else if (plan_flags.closing_flag) begin
      if (plan_flags.opening_flag) add_event(EV_OPEN_DONE, pick_len(), fail);
      else if (plan_flags.reading_flag && (!plan_flags.writing_flag || pick < 5))
        add_event(EV_READ_DONE, pick_len(), fail);
      else add_event(EV_WRITE_DONE, pick_len(), fail);
    end else if (plan_flags.opening_flag) begin
      if (roll < 25) add_event(EV_CLOSE, pick_len(), 1'($urandom_range(1)));
      else add_event(EV_OPEN_DONE, pick_len(), fail);
    end else if (!plan_flags.open_flag) begin
      add_event(EV_OPEN, pick_len(), 1'($urandom_range(1)));
    end else if (pick == 0) begin
      add_event(EV_CLOSE, pick_len(), 1'($urandom_range(1)));
    end else if (pick <= 4) begin
      if (!plan_flags.writing_flag)
        add_event(EV_WRITE_REQ, pick_len(), 1'($urandom_range(1)));
      else add_event(EV_WRITE_DONE, pick_len(), fail);
    end else begin
      if (!plan_flags.reading_flag)
        add_event(EV_READ_REQ, pick_len(), 1'($urandom_range(1)));
      else add_event(EV_READ_DONE, pick_len(), fail);
    end
  endtask

  // Hold until every queued beat has gone in and every result has come out.
  task automatic wait_drained();
    while (event_backlog.size() != 0 || evt_valid || owed_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Driver: advance to the next backlog beat once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (!evt_valid || !evt_stall) begin
      if (event_backlog.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
        evt <= event_backlog.pop_front();
        evt_valid <= 1'b1;
      end else begin
        evt_valid <= 1'b0;
      end
    end
  end

  // Monitor: predict each accepted event beat, then check each result beat.
  always @(posedge clk) begin : monitor
    step_t s;
    res_t  want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (evt_valid && !evt_stall) begin
        s = advance_channel(chan_flags, evt);
        chan_flags = s.f;
        owed_results.push_back(s.r);
        beats_in <= beats_in + 1;
      end
      if (res_valid && !res_stall) begin
        if (owed_results.size() == 0) begin
          $error("result beat with no event waiting for it");
          errors++;
        end else begin
          want = owed_results.pop_front();
          check_field("rejected", 16'(want.rejected), 16'(res.rejected));
          check_field("lower_cmd", 16'(want.lower_cmd), 16'(res.lower_cmd));
          check_field("xfer_len", want.xfer_len, res.xfer_len);
          check_field("notice", 16'(want.notice), 16'(res.notice));
          check_field("layer_down", 16'(want.layer_down), 16'(res.layer_down));
          check_field("is_open", 16'(want.is_open), 16'(res.is_open));
          check_field("is_opening", 16'(want.is_opening), 16'(res.is_opening));
          check_field("is_reading", 16'(want.is_reading), 16'(res.is_reading));
          check_field("is_writing", 16'(want.is_writing), 16'(res.is_writing));
          check_field("is_closing", 16'(want.is_closing), 16'(res.is_closing));
        end
      end
      res_stall <= !steady && ($urandom_range(99) < 25);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("link_channel_lifecycle_fsm: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: refusals from the reset state
    add_event(EV_CLOSE, 16'h0000, 1'b0);
    add_event(EV_UNUSED, 16'hFFFF, 1'b1);
    add_event(EV_READ_REQ, 16'h0001, 1'b0);
    add_event(EV_OPEN_DONE, 16'h0000, 1'b0);
    // open, refuse a second open, abort it, close again while closing, then finish the aborted open
    add_event(EV_OPEN, 16'h0000, 1'b0);
    add_event(EV_OPEN, 16'h0000, 1'b0);
    add_event(EV_CLOSE, 16'h0000, 1'b0);
    add_event(EV_CLOSE, 16'h0000, 1'b0);
    add_event(EV_OPEN_DONE, 16'h0000, 1'b0);
    // failed open, then a good one
    add_event(EV_OPEN, 16'h0000, 1'b0);
    add_event(EV_OPEN_DONE, 16'h0000, 1'b1);
    add_event(EV_OPEN, 16'h0000, 1'b0);
    add_event(EV_OPEN_DONE, 16'h0000, 1'b0);
    // zero-length requests complete at once; a second write while one is busy is refused
    add_event(EV_WRITE_REQ, 16'h0000, 1'b0);
    add_event(EV_READ_REQ, 16'h0000, 1'b0);
    add_event(EV_WRITE_REQ, 16'hFFFF, 1'b0);
    add_event(EV_WRITE_REQ, 16'h0001, 1'b0);
    add_event(EV_READ_REQ, 16'h0001, 1'b0);
    add_event(EV_READ_DONE, 16'hFFFF, 1'b0);
    // failed write with nothing else pending drops the link in one step
    add_event(EV_WRITE_DONE, 16'h0000, 1'b1);
    // close with both directions busy; late data is dropped
    add_event(EV_OPEN, 16'h0000, 1'b0);
    add_event(EV_OPEN_DONE, 16'h0000, 1'b0);
    add_event(EV_READ_REQ, 16'h5A5A, 1'b0);
    add_event(EV_WRITE_REQ, 16'hA5A5, 1'b1);
    add_event(EV_CLOSE, 16'h0000, 1'b0);
    add_event(EV_READ_DONE, 16'h1234, 1'b0);
    add_event(EV_WRITE_DONE, 16'h0000, 1'b1);
    wait_drained();

    // Random sessions, with one full drain halfway
    live_events = 0;
    while (live_events < LIVE_TARGET / 2) add_session_step();
    wait_drained();
    while (live_events < LIVE_TARGET) add_session_step();
    wait_drained();

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("link_channel_lifecycle_fsm: match");
    end else begin
      $display("link_channel_lifecycle_fsm: mismatch");
    end
    $finish;
  end

endmodule
